/* sv/tsp_pkg.sv */
// Shared types and constants for the slot pool with time-to-live expiry
`default_nettype none

package tsp_pkg;

  // pool geometry
  localparam int unsigned SLOTS        = 64;
  localparam int unsigned SLOT_W       = $clog2(SLOTS);
  localparam int unsigned SLOT_FIELD_W = 6;

  // stream widths
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned SEL_W      = 2;

  // request opcodes
  localparam logic [SEL_W-1:0] OP_ADD  = 2'd0;
  localparam logic [SEL_W-1:0] OP_TICK = 2'd1;
  localparam logic [SEL_W-1:0] OP_DUMP = 2'd2;

  // result kinds
  localparam logic [SEL_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [SEL_W-1:0] KIND_ENTRY = 2'd1;
  localparam logic [SEL_W-1:0] KIND_EMPTY = 2'd2;

  // one pool entry as held in memory
  typedef struct packed {
    logic [15:0]        ttl;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic signed [15:0] to_y;
    logic signed [15:0] to_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_x;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // what the output register takes on a load
  typedef enum logic [1:0] {
    OUT_ADD_OK   = 2'd0,
    OUT_ADD_FULL = 2'd1,
    OUT_ENTRY    = 2'd2,
    OUT_EMPTY    = 2'd3
  } out_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     idx_clr;
    logic     idx_inc;
    logic     ram_rd;
    logic     add_wr;
    logic     tick_wr;
    logic     dump_drop;
    logic     out_load;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic alive_cur;
    logic any_alive;
    logic idx_last;
    logic out_free;
    logic dump_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/tsp_ram.sv */
// Generic single write port, single read port RAM with registered read
`default_nettype none

module tsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/tsp_dp.sv */
// Datapath: slot counter, alive flags, entry memory, ttl update and result register
`default_nettype none

module tsp_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire tsp_pkg::ctrl_cmd_t             cmd_i,
  output tsp_pkg::dp_status_t                 status_o,
  input  wire logic [tsp_pkg::IN_DATA_W-1:0]  s_tdata_i,
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  output logic      [tsp_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic      [tsp_pkg::SEL_W-1:0]      m_tuser_o,
  output logic                                m_tlast_o
);

  logic [tsp_pkg::SLOT_W-1:0] idx_q, idx_d;
  logic [tsp_pkg::SLOTS-1:0]  alive_q, alive_d;
  logic [tsp_pkg::SLOTS-1:0]  dump_vec_q, dump_vec_d;
  logic [tsp_pkg::SLOTS-1:0]  idx_dec;

  tsp_pkg::entry_t in_ent_q;
  logic [15:0]     delta_q;

  tsp_pkg::entry_t rd_ent;
  tsp_pkg::entry_t tick_ent;
  logic [15:0]     tick_ttl;
  tsp_pkg::entry_t wr_ent;

  logic                               m_valid_q, m_valid_d;
  logic [tsp_pkg::SEL_W-1:0]          kind_q;
  logic                               acc_q;
  logic [tsp_pkg::SLOT_FIELD_W-1:0]   slot_q;
  tsp_pkg::entry_t                    ent_q;
  logic                               last_q;

  // slot decoder
  always_comb begin
    for (int i = 0; i < tsp_pkg::SLOTS; i++) begin
      idx_dec[i] = (idx_q == tsp_pkg::SLOT_W'(i));
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_ent_q.from_x <= s_tdata_i[15:0];
      in_ent_q.from_y <= s_tdata_i[31:16];
      in_ent_q.to_x   <= s_tdata_i[47:32];
      in_ent_q.to_y   <= s_tdata_i[63:48];
      in_ent_q.red    <= s_tdata_i[71:64];
      in_ent_q.green  <= s_tdata_i[79:72];
      in_ent_q.blue   <= s_tdata_i[87:80];
      in_ent_q.ttl    <= s_tdata_i[103:88];
      delta_q         <= s_tdata_i[119:104];
    end
  end

  // saturating ttl decrement on the entry just read
  always_comb begin
    tick_ttl     = (rd_ent.ttl > delta_q) ? (rd_ent.ttl - delta_q) : 16'd0;
    tick_ent     = rd_ent;
    tick_ent.ttl = tick_ttl;
    wr_ent       = cmd_i.add_wr ? in_ent_q : tick_ent;
  end

  // entry memory
  tsp_ram #(
    .WIDTH (tsp_pkg::ENTRY_W),
    .DEPTH (tsp_pkg::SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_wr | cmd_i.tick_wr),
    .waddr_i (idx_q),
    .wdata_i (wr_ent),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (idx_q),
    .rdata_o (rd_ent)
  );

  // slot counter, alive flags and dump bookkeeping
  always_comb begin
    idx_d      = idx_q;
    alive_d    = alive_q;
    dump_vec_d = dump_vec_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + tsp_pkg::SLOT_W'(1);
    end
    if (cmd_i.add_wr) begin
      alive_d = alive_q | idx_dec;
    end else if (cmd_i.tick_wr && (tick_ttl == 16'd0)) begin
      alive_d = alive_q & ~idx_dec;
    end
    if (cmd_i.capture) begin
      dump_vec_d = alive_q;
    end else if (cmd_i.dump_drop) begin
      dump_vec_d = dump_vec_q & ~idx_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      alive_q    <= '0;
      dump_vec_q <= '0;
    end else begin
      idx_q      <= idx_d;
      alive_q    <= alive_d;
      dump_vec_q <= dump_vec_d;
    end
  end

  // result register valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        tsp_pkg::OUT_ADD_OK: begin
          kind_q <= tsp_pkg::KIND_ADD;
          acc_q  <= 1'b1;
          slot_q <= tsp_pkg::SLOT_FIELD_W'(idx_q);
          ent_q  <= in_ent_q;
          last_q <= 1'b1;
        end
        tsp_pkg::OUT_ENTRY: begin
          kind_q <= tsp_pkg::KIND_ENTRY;
          acc_q  <= 1'b0;
          slot_q <= tsp_pkg::SLOT_FIELD_W'(idx_q);
          ent_q  <= rd_ent;
          last_q <= status_o.dump_last;
        end
        tsp_pkg::OUT_EMPTY: begin
          kind_q <= tsp_pkg::KIND_EMPTY;
          acc_q  <= 1'b0;
          slot_q <= '0;
          ent_q  <= '0;
          last_q <= 1'b1;
        end
        default: begin
          kind_q <= tsp_pkg::KIND_ADD;
          acc_q  <= 1'b0;
          slot_q <= '0;
          ent_q  <= '0;
          last_q <= 1'b1;
        end
      endcase
    end
  end

  // status back to the controller
  always_comb begin
    status_o.alive_cur = |(alive_q & idx_dec);
    status_o.any_alive = |alive_q;
    status_o.idx_last  = (idx_q == tsp_pkg::SLOT_W'(tsp_pkg::SLOTS - 1));
    status_o.out_free  = ~m_valid_q | m_tready_i;
    status_o.dump_last = ~|(dump_vec_q & ~idx_dec);
  end

  // output packing
  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = kind_q;
  assign m_tlast_o  = last_q;
  assign m_tdata_o  = {1'b0, ent_q.ttl, ent_q.blue, ent_q.green, ent_q.red,
                       ent_q.to_y, ent_q.to_x, ent_q.from_y, ent_q.from_x,
                       slot_q, acc_q};

endmodule

`default_nettype wire

/* sv/tsp_ctrl.sv */
// Controller: sequences add, tick and dump requests over the slots
`default_nettype none

module tsp_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_tvalid_i,
  input  wire logic [tsp_pkg::SEL_W-1:0] op_i,
  output logic                           s_tready_o,
  input  wire tsp_pkg::dp_status_t       status_i,
  output tsp_pkg::ctrl_cmd_t             cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_ADD       = 8'b0000_0010,
    ST_TICK_SCAN = 8'b0000_0100,
    ST_TICK_WR   = 8'b0000_1000,
    ST_DUMP_SCAN = 8'b0001_0000,
    ST_DUMP_OUT  = 8'b0010_0000,
    ST_EMPTY     = 8'b0100_0000,
    ST_SPARE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i & s_tready_o;

  // next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o.capture   = 1'b0;
    cmd_o.idx_clr   = 1'b0;
    cmd_o.idx_inc   = 1'b0;
    cmd_o.ram_rd    = 1'b0;
    cmd_o.add_wr    = 1'b0;
    cmd_o.tick_wr   = 1'b0;
    cmd_o.dump_drop = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.out_sel   = tsp_pkg::OUT_ADD_OK;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          cmd_o.idx_clr = 1'b1;
          if (op_i == tsp_pkg::OP_ADD) begin
            state_d = ST_ADD;
          end else if (op_i == tsp_pkg::OP_TICK) begin
            state_d = ST_TICK_SCAN;
          end else if (op_i == tsp_pkg::OP_DUMP) begin
            state_d = status_i.any_alive ? ST_DUMP_SCAN : ST_EMPTY;
          end
        end
      end
      // look for the lowest free slot
      ST_ADD: begin
        if (!status_i.alive_cur) begin
          if (status_i.out_free) begin
            cmd_o.add_wr   = 1'b1;
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = tsp_pkg::OUT_ADD_OK;
            state_d        = ST_IDLE;
          end
        end else if (status_i.idx_last) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = tsp_pkg::OUT_ADD_FULL;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      // read each live entry, then write back its decremented ttl
      ST_TICK_SCAN: begin
        if (status_i.alive_cur) begin
          cmd_o.ram_rd = 1'b1;
          state_d      = ST_TICK_WR;
        end else if (status_i.idx_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_TICK_WR: begin
        cmd_o.tick_wr = 1'b1;
        if (status_i.idx_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_TICK_SCAN;
        end
      end
      // read each live entry and hand it to the result register
      ST_DUMP_SCAN: begin
        if (status_i.alive_cur) begin
          cmd_o.ram_rd = 1'b1;
          state_d      = ST_DUMP_OUT;
        end else if (status_i.idx_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_DUMP_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = tsp_pkg::OUT_ENTRY;
          cmd_o.dump_drop = 1'b1;
          if (status_i.dump_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_DUMP_SCAN;
          end
        end
      end
      ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = tsp_pkg::OUT_EMPTY;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* sv/ttl_slot_pool.sv */
// Top level: slot pool with add, time-to-live tick and dump requests
// Add: scans up from slot 0 over occupied slots to the lowest free one (or the last slot),
// plus any wait while an earlier result still sits in the output register.
// Tick: visits every slot; a live slot takes a memory read, then a write back.
// Dump: visits slots up to the last live one and reads each live entry, waiting
// while results are stalled; an empty pool gives its marker.
// One request at a time, taken in idle; reset clears alive flags and control state only.
`default_nettype none

module ttl_slot_pool (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_tvalid_i,
  output logic                                     s_tready_o,
  // from_x, from_y, to_x, to_y, red, green, blue, lifetime, delta
  input  wire logic [tsp_pkg::IN_DATA_W-1:0]       s_tdata_i,
  // op
  input  wire logic [tsp_pkg::SEL_W-1:0]           s_tuser_i,
  output logic                                     m_tvalid_o,
  input  wire logic                                m_tready_i,
  // accepted, slot, out_from_x, out_from_y, out_to_x, out_to_y,
  // out_red, out_green, out_blue, ttl_left, one pad bit
  output logic      [tsp_pkg::OUT_DATA_W-1:0]      m_tdata_o,
  // kind
  output logic      [tsp_pkg::SEL_W-1:0]           m_tuser_o,
  output logic                                     m_tlast_o
);

  tsp_pkg::ctrl_cmd_t  cmd;
  tsp_pkg::dp_status_t status;

  // sequencing
  tsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .op_i       (s_tuser_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage and result path
  tsp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  // a result is never loaded over one that is still waiting
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten");

  // an add never lands on a live slot
  a_add_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.add_wr |-> !status.alive_cur)
    else $error("add wrote a live slot");

  // add status and empty marker are single results
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == tsp_pkg::KIND_ADD || m_tuser_o == tsp_pkg::KIND_EMPTY)
    |-> m_tlast_o)
    else $error("single result without last");

  // a stored add is followed by that slot reading as live
  a_add_sets_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.add_wr |=> status.alive_cur)
    else $error("added slot not marked live");

endmodule

`default_nettype wire

/* dv/ttl_slot_pool_checker.sv */
// Checker for the slot pool: mirrors pool contents and checks every result beat
`default_nettype none

module ttl_slot_pool_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid_i,
  input  wire logic                          s_tready_i,
  // from_x, from_y, to_x, to_y, red, green, blue, lifetime, delta
  input  wire logic [tsp_pkg::IN_DATA_W-1:0] s_tdata_i,
  // op
  input  wire logic [tsp_pkg::SEL_W-1:0]     s_tuser_i,
  input  wire logic                          m_tvalid_i,
  input  wire logic                          m_tready_i,
  // accepted, slot, out_from_x, out_from_y, out_to_x, out_to_y,
  // out_red, out_green, out_blue, ttl_left, one pad bit
  input  wire logic [tsp_pkg::OUT_DATA_W-1:0] m_tdata_i,
  // kind
  input  wire logic [tsp_pkg::SEL_W-1:0]     m_tuser_i,
  input  wire logic                          m_tlast_i,
  output int                                 mismatch_o,
  output int                                 pending_o,
  output int                                 checked_o,
  output int                                 refused_o
);
  import tsp_pkg::*;

  // request payload, highest field first
  typedef struct packed {
    logic [15:0] delta;
    logic [15:0] lifetime;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] to_y;
    logic [15:0] to_x;
    logic [15:0] from_y;
    logic [15:0] from_x;
  } pool_req_t;

  // result payload, highest field first
  typedef struct packed {
    logic        pad;
    logic [15:0] ttl_left;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] to_y;
    logic [15:0] to_x;
    logic [15:0] from_y;
    logic [15:0] from_x;
    logic [5:0]  slot;
    logic        accepted;
  } pool_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
    pool_beat_t beat;
  } pool_result_t;

  // mirrored pool contents
  logic [SLOTS-1:0] live_slots;
  entry_t           entry_mem [SLOTS];

  pool_result_t expected_results [$];
  int           mismatches;
  int           beats_checked;
  int           adds_refused;

  assign mismatch_o = mismatches;
  assign pending_o  = expected_results.size();
  assign checked_o  = beats_checked;
  assign refused_o  = adds_refused;

  initial begin
    mismatches    = 0;
    beats_checked = 0;
    adds_refused  = 0;
  end

  // entry fields as they appear on the result stream
  function automatic pool_beat_t entry_beat(input int s);
    pool_beat_t b;
    b          = '0;
    b.slot     = s[5:0];
    b.from_x   = entry_mem[s].from_x;
    b.from_y   = entry_mem[s].from_y;
    b.to_x     = entry_mem[s].to_x;
    b.to_y     = entry_mem[s].to_y;
    b.red      = entry_mem[s].red;
    b.green    = entry_mem[s].green;
    b.blue     = entry_mem[s].blue;
    b.ttl_left = entry_mem[s].ttl;
    return b;
  endfunction

  // apply one request to the mirror and queue the beats it should produce
  task automatic predict_request(input logic [1:0] op, input pool_req_t req);
    pool_result_t res;
    int           free_slot;
    int           live_total;
    int           emitted;
    logic [15:0]  left;
    res = '0;
    case (op)
      OP_ADD: begin
        res.kind  = KIND_ADD;
        res.last  = 1'b1;
        free_slot = -1;
        for (int s = SLOTS - 1; s >= 0; s--) begin
          if (!live_slots[s]) free_slot = s;
        end
        if (free_slot >= 0) begin
          entry_mem[free_slot] = '{ttl: req.lifetime, blue: req.blue, green: req.green,
                                   red: req.red, to_y: req.to_y, to_x: req.to_x,
                                   from_y: req.from_y, from_x: req.from_x};
          live_slots[free_slot] = 1'b1;
          res.beat              = entry_beat(free_slot);
          res.beat.accepted     = 1'b1;
        end else begin
          adds_refused++;
        end
        expected_results.push_back(res);
      end
      OP_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (live_slots[s]) begin
            left = (entry_mem[s].ttl > req.delta) ? entry_mem[s].ttl - req.delta : 16'd0;
            entry_mem[s].ttl = left;
            if (left == 16'd0) live_slots[s] = 1'b0;
          end
        end
      end
      OP_DUMP: begin
        live_total = $countones(live_slots);
        emitted    = 0;
        if (live_total == 0) begin
          res.kind = KIND_EMPTY;
          res.last = 1'b1;
          expected_results.push_back(res);
        end else begin
          for (int s = 0; s < SLOTS; s++) begin
            if (live_slots[s]) begin
              emitted++;
              res.kind = KIND_ENTRY;
              res.beat = entry_beat(s);
              res.last = (emitted == live_total);
              expected_results.push_back(res);
            end
          end
        end
      end
      default: begin
        // unused opcode leaves the pool alone
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // compare one result beat with the oldest expectation
  task automatic check_beat();
    pool_result_t want;
    pool_beat_t   got;
    got = m_tdata_i;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d slot %0d", m_tuser_i, got.slot);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      beats_checked++;
      check_field("kind", 16'(want.kind), 16'(m_tuser_i));
      check_field("last", 16'(want.last), 16'(m_tlast_i));
      check_field("accepted", 16'(want.beat.accepted), 16'(got.accepted));
      check_field("slot", 16'(want.beat.slot), 16'(got.slot));
      check_field("out_from_x", want.beat.from_x, got.from_x);
      check_field("out_from_y", want.beat.from_y, got.from_y);
      check_field("out_to_x", want.beat.to_x, got.to_x);
      check_field("out_to_y", want.beat.to_y, got.to_y);
      check_field("out_red", 16'(want.beat.red), 16'(got.red));
      check_field("out_green", 16'(want.beat.green), 16'(got.green));
      check_field("out_blue", 16'(want.beat.blue), 16'(got.blue));
      check_field("ttl_left", want.beat.ttl_left, got.ttl_left);
      check_field("pad", 16'(want.beat.pad), 16'(got.pad));
    end
  endtask

  // requests are predicted before results of the same edge are compared
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_slots = '0;
      expected_results.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) predict_request(s_tuser_i, s_tdata_i);
      if (m_tvalid_i && m_tready_i) check_beat();
    end
  end

endmodule

`default_nettype wire

/* dv/ttl_slot_pool_tb.sv */
// Testbench top for the slot pool: clock, reset, request stimulus and verdict
`default_nettype none

module ttl_slot_pool_tb;
  import tsp_pkg::*;

  localparam logic [SEL_W-1:0] OP_UNUSED    = 2'd3;
  localparam int               RANDOM_ITEMS = 380;

  typedef struct packed {
    logic [15:0] delta;
    logic [15:0] lifetime;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] to_y;
    logic [15:0] to_x;
    logic [15:0] from_y;
    logic [15:0] from_x;
  } pool_req_t;

  // traffic mix of one random round
  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [SEL_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [SEL_W-1:0]      m_tuser;
  logic                  m_tlast;

  int   mismatches;
  int   pending;
  int   beats_checked;
  int   adds_refused;
  int   sent = 0;
  int   ignored = 0;
  logic steady = 1'b0;

  ttl_slot_pool DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );

  ttl_slot_pool_checker u_pool_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .m_tlast_i  (m_tlast),
    .mismatch_o (mismatches),
    .pending_o  (pending),
    .checked_o  (beats_checked),
    .refused_o  (adds_refused)
  );

  // 12-unit clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side backpressure
  always @(negedge clk_i) begin
    m_tready <= steady || ($urandom_range(99) >= 10);
  end

  function automatic pool_req_t random_req();
    logic [127:0] raw_bits;
    raw_bits = {$urandom, $urandom, $urandom, $urandom};
    return raw_bits[IN_DATA_W-1:0];
  endfunction

  // present one request, with an occasional gap before it, and wait for acceptance
  task automatic send_req(input logic [SEL_W-1:0] op, input pool_req_t req);
    while (!steady && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= req;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if (op == OP_UNUSED) ignored++;
  endtask

  // stimulus
  initial begin
    pool_req_t        req;
    mix_e             mix;
    logic [SEL_W-1:0] op;
    int               round_len;
    int               n;
    int               pick;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty pool: dump marker, tick with nothing live, unused opcode
    send_req(OP_DUMP, random_req());
    req = random_req();
    req.delta = 16'hFFFF;
    send_req(OP_TICK, req);
    send_req(OP_UNUSED, random_req());

    // coordinate and color extremes, longest lifetime
    req = random_req();
    req.from_x = 16'h8000; req.from_y = 16'h7FFF; req.to_x = 16'h0000; req.to_y = 16'hFFFF;
    req.red = 8'hFF; req.green = 8'h00; req.blue = 8'hFF; req.lifetime = 16'hFFFF;
    send_req(OP_ADD, req);
    // opposite extremes with zero lifetime
    req = random_req();
    req.from_x = 16'h7FFF; req.from_y = 16'h8000; req.to_x = 16'hFFFF; req.to_y = 16'h0000;
    req.red = 8'h00; req.green = 8'hFF; req.blue = 8'h00; req.lifetime = 16'h0000;
    send_req(OP_ADD, req);
    req = random_req();
    req.lifetime = 16'h0001;
    send_req(OP_ADD, req);
    req = random_req();
    req.lifetime = 16'h0100;
    send_req(OP_ADD, req);
    send_req(OP_DUMP, random_req());

    // zero delta still frees the zero-lifetime entry
    req = random_req();
    req.delta = 16'h0000;
    send_req(OP_TICK, req);
    send_req(OP_DUMP, random_req());
    req = random_req();
    req.delta = 16'h0001;
    send_req(OP_TICK, req);
    send_req(OP_DUMP, random_req());

    // freed slot is reused as the lowest free one
    req = random_req();
    req.lifetime = 16'h4000;
    send_req(OP_ADD, req);
    send_req(OP_DUMP, random_req());

    // full delta saturates every entry to zero
    req = random_req();
    req.delta = 16'hFFFF;
    send_req(OP_TICK, req);
    send_req(OP_DUMP, random_req());

    // random rounds, starting with one that overfills the pool
    n   = 0;
    mix = MIX_FILL;
    while (n < RANDOM_ITEMS) begin
      round_len = (mix == MIX_FILL) ? 80 : (mix == MIX_CHURN) ? 60 : 20;
      for (int i = 0; i < round_len && n < RANDOM_ITEMS; i++) begin
        steady = (n >= 150 && n < 230);
        req    = random_req();
        pick   = $urandom_range(99);
        case (mix)
          MIX_FILL: begin
            op = (i % 12 == 11) ? OP_DUMP : OP_ADD;
            req.lifetime = 16'($urandom_range(16'hFFFF, 16'h8000));
          end
          MIX_CHURN: begin
            if (pick < 45) begin
              op = OP_ADD;
              case ($urandom_range(3))
                0:       req.lifetime = 16'($urandom_range(16'h00FF));
                1:       req.lifetime = 16'($urandom_range(16'h1000, 16'h0100));
                default: req.lifetime = 16'($urandom_range(16'hFFFF));
              endcase
            end else if (pick < 75) begin
              op = OP_TICK;
              if ($urandom_range(7) != 0) req.delta = 16'($urandom_range(16'h0300));
            end else if (pick < 95) begin
              op = OP_DUMP;
            end else begin
              op = OP_UNUSED;
            end
          end
          default: begin
            op = (pick < 70) ? OP_TICK : OP_DUMP;
            req.delta = 16'($urandom_range(16'h4000, 16'h0800));
          end
        endcase
        send_req(op, req);
        if (op != OP_UNUSED) n++;
      end
      mix = mix_e'($urandom_range(2));
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    // drain outstanding results, then let a trailing tick finish
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);

    $display("ran %0d requests (%0d with the unused opcode), checked %0d result beats",
             sent, ignored, beats_checked);
    $display("%0d adds were refused on a full pool", adds_refused);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
